// File: hdl/omw_pkg.sv
// omw_pkg: shared types, widths and constants for the omni wheel mixer
// no dependencies

`default_nettype none

package omw_pkg;

  localparam int FRAC_BITS_DEF  = 12;
  localparam int GUARD_BITS     = 4;
  localparam int NUM_WHEELS     = 3;

  // translation terms carry a 2^16 scale, magnitude below 2^32
  localparam int T_W            = 33;
  localparam int SQR_W          = 31;
  localparam int MAG2_W         = 32;
  localparam int SQ_IN_W        = MAG2_W + 2 * GUARD_BITS;
  localparam int SQ_W           = SQ_IN_W + 1;
  localparam int ROOT_W         = SQ_IN_W / 2;
  localparam int SQ_STEPS       = ROOT_W;
  localparam int SQ_PER_STAGE   = 2;
  localparam int SQ_STAGES      = SQ_STEPS / SQ_PER_STAGE;
  localparam int VRM_W          = 37;
  localparam int Q_W            = 7;

  localparam int FRONT_STAGES   = 2;
  localparam int MIX_STAGES     = 4;
  localparam int PIPE_LAT       = FRONT_STAGES + SQ_STAGES + MIX_STAGES + Q_W + 1;

  localparam logic signed [T_W-1:0] HALF_SQRT3_Q16 = 33'sd56756;
  localparam logic signed [7:0]     OUT_MAX        = 8'sd127;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_rot;
  } omw_in_t;

  typedef struct packed {
    logic signed [7:0] wheel_front;
    logic signed [7:0] wheel_rear_left;
    logic signed [7:0] wheel_rear_right;
  } omw_out_t;

  typedef struct packed {
    logic signed [T_W-1:0] t0;
    logic signed [T_W-1:0] t1;
    logic signed [T_W-1:0] t2;
    logic signed [15:0]    vr;
    logic                  norm;
  } omw_side_t;

endpackage

`default_nettype wire

// File: hdl/omw_front.sv
// omw_front: rotation clamp, translation terms and squared magnitude (two stages)
// depends on omw_pkg

`default_nettype none

module omw_front import omw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire omw_in_t   in_data,
  output logic           out_valid,
  output omw_side_t      out_side,
  output logic [SQ_IN_W-1:0] out_mag2
);

  localparam logic signed [15:0] ONE     = 16'(1 << FRAC_BITS);
  localparam logic signed [15:0] NEG_ONE = -ONE;
  localparam logic [MAG2_W-1:0]  ONE_SQ  = MAG2_W'(1) << (2 * FRAC_BITS);

  logic                  s1_valid_r;
  logic signed [15:0]    s1_vx_r;
  logic signed [15:0]    s1_vr_r;
  logic signed [T_W-1:0] s1_ky_r;
  logic [SQR_W-1:0]      s1_sqx_r;
  logic [SQR_W-1:0]      s1_sqy_r;

  logic signed [15:0]    vr_nxt;
  logic signed [31:0]    vx_e, vy_e, sqx, sqy;
  logic signed [T_W-1:0] ky_nxt;

  always_comb begin
    if (in_data.vel_rot > ONE) begin
      vr_nxt = ONE;
    end else if (in_data.vel_rot < NEG_ONE) begin
      vr_nxt = NEG_ONE;
    end else begin
      vr_nxt = in_data.vel_rot;
    end
    vx_e   = 32'(in_data.vel_x);
    vy_e   = 32'(in_data.vel_y);
    sqx    = vx_e * vx_e;
    sqy    = vy_e * vy_e;
    ky_nxt = T_W'(in_data.vel_y) * HALF_SQRT3_Q16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
    s1_vx_r  <= in_data.vel_x;
    s1_vr_r  <= vr_nxt;
    s1_ky_r  <= ky_nxt;
    s1_sqx_r <= sqx[SQR_W-1:0];
    s1_sqy_r <= sqy[SQR_W-1:0];
  end

  logic signed [T_W-1:0] vx_w, vx_half;
  logic [MAG2_W-1:0]     mag2;
  omw_side_t             side_nxt;

  always_comb begin
    vx_w          = T_W'(s1_vx_r);
    vx_half       = vx_w <<< 15;
    mag2          = MAG2_W'(s1_sqx_r) + MAG2_W'(s1_sqy_r);
    side_nxt.t0   = -(vx_w <<< 16);
    side_nxt.t1   = vx_half - s1_ky_r;
    side_nxt.t2   = vx_half + s1_ky_r;
    side_nxt.vr   = s1_vr_r;
    side_nxt.norm = mag2 > ONE_SQ;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid_r;
    end
    out_side <= side_nxt;
    out_mag2 <= {mag2, (2 * GUARD_BITS)'(0)};
  end

endmodule

`default_nettype wire

// File: hdl/omw_sqrt.sv
// omw_sqrt: pipelined integer square root, two result bits per stage
// depends on omw_pkg

`default_nettype none

module omw_sqrt import omw_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire omw_side_t          in_side,
  input  wire logic [SQ_IN_W-1:0] in_x,
  output logic                    out_valid,
  output omw_side_t               out_side,
  output logic [ROOT_W-1:0]       out_root
);

  logic            v_r    [SQ_STAGES];
  omw_side_t       side_r [SQ_STAGES];
  logic [SQ_W-1:0] x_r    [SQ_STAGES];
  logic [SQ_W-1:0] res_r  [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic            v_src;
    omw_side_t       side_src;
    logic [SQ_W-1:0] x_src, res_src, x_c, res_c;

    if (g == 0) begin : g_first
      assign v_src    = in_valid;
      assign side_src = in_side;
      assign x_src    = SQ_W'(in_x);
      assign res_src  = '0;
    end else begin : g_next
      assign v_src    = v_r[g-1];
      assign side_src = side_r[g-1];
      assign x_src    = x_r[g-1];
      assign res_src  = res_r[g-1];
    end

    always_comb begin
      logic [SQ_W-1:0] b;
      logic [SQ_W-1:0] trial;
      x_c   = x_src;
      res_c = res_src;
      for (int k = 0; k < SQ_PER_STAGE; k++) begin
        b     = SQ_W'(1) << (2 * (SQ_STEPS - 1 - (g * SQ_PER_STAGE + k)));
        trial = res_c + b;
        if (x_c >= trial) begin
          x_c   = x_c - trial;
          res_c = (res_c >> 1) + b;
        end else begin
          res_c = res_c >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else begin
        v_r[g] <= v_src;
      end
      side_r[g] <= side_src;
      x_r[g]    <= x_c;
      res_r[g]  <= res_c;
    end
  end

  assign out_valid = v_r[SQ_STAGES-1];
  assign out_side  = side_r[SQ_STAGES-1];
  assign out_root  = res_r[SQ_STAGES-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// File: hdl/omw_mix.sv
// omw_mix: wheel speed mixing, magnitudes, largest magnitude and 127x numerators
// depends on omw_pkg

`default_nettype none

module omw_mix import omw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int WW = 38 + FRAC_BITS,
  localparam int NW = WW + Q_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire omw_side_t         in_side,
  input  wire logic [ROOT_W-1:0] in_root,
  output logic                   out_valid,
  output logic [NW-1:0]          out_num [NUM_WHEELS],
  output logic [WW-1:0]          out_den,
  output logic                   out_neg [NUM_WHEELS],
  output logic                   out_zero
);

  // stage 1: rotation times magnitude
  logic                    m1_valid_r;
  omw_side_t               m1_side_r;
  logic signed [VRM_W-1:0] m1_vrm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
    end else begin
      m1_valid_r <= in_valid;
    end
    m1_side_r <= in_side;
    m1_vrm_r  <= VRM_W'(in_side.vr) * $signed({(VRM_W - ROOT_W)'(0), in_root});
  end

  // stage 2: speeds
  logic                 m2_valid_r;
  logic signed [WW-1:0] m2_w_r [NUM_WHEELS];
  logic signed [WW-1:0] w_nxt  [NUM_WHEELS];
  logic signed [WW-1:0] t_e    [NUM_WHEELS];

  always_comb begin
    t_e[0] = WW'(m1_side_r.t0);
    t_e[1] = WW'(m1_side_r.t1);
    t_e[2] = WW'(m1_side_r.t2);
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (m1_side_r.norm) begin
        w_nxt[i] = (t_e[i] <<< (FRAC_BITS + GUARD_BITS)) + (WW'(m1_vrm_r) <<< 16);
      end else begin
        w_nxt[i] = t_e[i] + (WW'(m1_side_r.vr) <<< 16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_valid_r <= 1'b0;
    end else begin
      m2_valid_r <= m1_valid_r;
    end
    m2_w_r <= w_nxt;
  end

  // stage 3: magnitudes and signs
  logic          m3_valid_r;
  logic [WW-1:0] m3_abs_r [NUM_WHEELS];
  logic          m3_neg_r [NUM_WHEELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_valid_r <= 1'b0;
    end else begin
      m3_valid_r <= m2_valid_r;
    end
    for (int i = 0; i < NUM_WHEELS; i++) begin
      m3_neg_r[i] <= m2_w_r[i][WW-1];
      m3_abs_r[i] <= m2_w_r[i][WW-1] ? WW'(-m2_w_r[i]) : WW'(m2_w_r[i]);
    end
  end

  // stage 4: largest magnitude and 127 * |w|
  logic [WW-1:0] max01, max_all;

  always_comb begin
    max01   = (m3_abs_r[1] > m3_abs_r[0]) ? m3_abs_r[1] : m3_abs_r[0];
    max_all = (m3_abs_r[2] > max01) ? m3_abs_r[2] : max01;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= m3_valid_r;
    end
    for (int i = 0; i < NUM_WHEELS; i++) begin
      out_num[i] <= (NW'(m3_abs_r[i]) << Q_W) - NW'(m3_abs_r[i]);
    end
    out_neg  <= m3_neg_r;
    out_den  <= max_all;
    out_zero <= (max_all == '0);
  end

endmodule

`default_nettype wire

// File: hdl/omw_div.sv
// omw_div: pipelined restoring divider, one quotient bit per stage, three lanes
// depends on omw_pkg

`default_nettype none

module omw_div import omw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int WW = 38 + FRAC_BITS,
  localparam int NW = WW + Q_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num [NUM_WHEELS],
  input  wire logic [WW-1:0] in_den,
  input  wire logic          in_neg [NUM_WHEELS],
  input  wire logic          in_zero,
  output logic               out_strobe,
  output omw_out_t           out_data
);

  logic           v_r    [Q_W];
  logic [NW-1:0]  n_r    [Q_W][NUM_WHEELS];
  logic [Q_W-1:0] q_r    [Q_W][NUM_WHEELS];
  logic [WW-1:0]  den_r  [Q_W];
  logic           neg_r  [Q_W][NUM_WHEELS];
  logic           zero_r [Q_W];

  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    logic           v_src;
    logic [NW-1:0]  n_src [NUM_WHEELS];
    logic [Q_W-1:0] q_src [NUM_WHEELS];
    logic [WW-1:0]  den_src;
    logic           neg_src [NUM_WHEELS];
    logic           zero_src;
    logic [NW-1:0]  n_c [NUM_WHEELS];
    logic [Q_W-1:0] q_c [NUM_WHEELS];
    logic [NW-1:0]  d_sh;

    if (g == 0) begin : g_first
      assign v_src    = in_valid;
      assign n_src    = in_num;
      assign q_src    = '{default: '0};
      assign den_src  = in_den;
      assign neg_src  = in_neg;
      assign zero_src = in_zero;
    end else begin : g_next
      assign v_src    = v_r[g-1];
      assign n_src    = n_r[g-1];
      assign q_src    = q_r[g-1];
      assign den_src  = den_r[g-1];
      assign neg_src  = neg_r[g-1];
      assign zero_src = zero_r[g-1];
    end

    assign d_sh = NW'(den_src) << (Q_W - 1 - g);

    always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        q_c[i] = q_src[i];
        if (n_src[i] >= d_sh) begin
          n_c[i]             = n_src[i] - d_sh;
          q_c[i][Q_W-1-g]    = 1'b1;
        end else begin
          n_c[i]             = n_src[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else begin
        v_r[g] <= v_src;
      end
      n_r[g]    <= n_c;
      q_r[g]    <= q_c;
      den_r[g]  <= den_src;
      neg_r[g]  <= neg_src;
      zero_r[g] <= zero_src;
    end
  end

  logic signed [7:0] o_nxt [NUM_WHEELS];

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (zero_r[Q_W-1]) begin
        o_nxt[i] = '0;
      end else if (neg_r[Q_W-1][i]) begin
        o_nxt[i] = 8'sd0 - $signed({1'b0, q_r[Q_W-1][i]});
      end else begin
        o_nxt[i] = $signed({1'b0, q_r[Q_W-1][i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= v_r[Q_W-1];
    end
    out_data.wheel_front      <= o_nxt[0];
    out_data.wheel_rear_left  <= o_nxt[1];
    out_data.wheel_rear_right <= o_nxt[2];
  end

endmodule

`default_nettype wire

// File: hdl/omni_wheel_mixer.sv
// omni_wheel_mixer: three-wheel omni drive mixer, one command per cycle, never busy
// out_strobe is high for one cycle for each start transfer
// throughput: one command every cycle; 10 square-root stages and 7 divider stages set depth
// the receiver cannot hold results off, so the pipeline never stalls
// reset: synchronous active-low rst_n clears every stage valid; no result survives reset
// depends on omw_pkg, omw_front, omw_sqrt, omw_mix, omw_div

`default_nettype none

module omni_wheel_mixer import omw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire omw_in_t in_data,
  output logic         out_strobe,
  output omw_out_t     out_data
);

  localparam int WW = 38 + FRAC_BITS;
  localparam int NW = WW + Q_W;

  logic               accept;
  logic               fr_valid, sq_valid, mx_valid;
  omw_side_t          fr_side, sq_side;
  logic [SQ_IN_W-1:0] fr_mag2;
  logic [ROOT_W-1:0]  sq_root;
  logic [NW-1:0]      mx_num [NUM_WHEELS];
  logic [WW-1:0]      mx_den;
  logic               mx_neg [NUM_WHEELS];
  logic               mx_zero;

  // fully pipelined, so a command is always taken
  assign busy   = 1'b0;
  assign accept = start && !busy;

  omw_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_data  (in_data),
    .out_valid(fr_valid),
    .out_side (fr_side),
    .out_mag2 (fr_mag2)
  );

  omw_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (fr_valid),
    .in_side  (fr_side),
    .in_x     (fr_mag2),
    .out_valid(sq_valid),
    .out_side (sq_side),
    .out_root (sq_root)
  );

  omw_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sq_valid),
    .in_side  (sq_side),
    .in_root  (sq_root),
    .out_valid(mx_valid),
    .out_num  (mx_num),
    .out_den  (mx_den),
    .out_neg  (mx_neg),
    .out_zero (mx_zero)
  );

  omw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mx_valid),
    .in_num    (mx_num),
    .in_den    (mx_den),
    .in_neg    (mx_neg),
    .in_zero   (mx_zero),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: hdl/omw_checker.sv
// omw_checker: port-level assertions for omni_wheel_mixer, bound to the top level
// depends on omw_pkg

`default_nettype none

module omw_checker import omw_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire omw_in_t  in_data,
  input wire logic     out_strobe,
  input wire omw_out_t out_data
);

  localparam int CW = $clog2(PIPE_LAT + 1);

  logic [CW-1:0] warm_r;
  logic          warm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
    end else if (warm_r != CW'(PIPE_LAT)) begin
      warm_r <= warm_r + 1'b1;
    end
  end

  assign warm = (warm_r == CW'(PIPE_LAT));

  // one result per transfer at fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_strobe == $past(start && !busy, PIPE_LAT)))
    else $error("result strobe does not match transfer history");

  // never reaches -128
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.wheel_front != -8'sd128 &&
                    out_data.wheel_rear_left != -8'sd128 &&
                    out_data.wheel_rear_right != -8'sd128))
    else $error("wheel value out of range");

  // a nonzero result always has a wheel at full scale
  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data != '0) |->
      (out_data.wheel_front == OUT_MAX || out_data.wheel_front == -OUT_MAX ||
       out_data.wheel_rear_left == OUT_MAX || out_data.wheel_rear_left == -OUT_MAX ||
       out_data.wheel_rear_right == OUT_MAX || out_data.wheel_rear_right == -OUT_MAX))
    else $error("largest wheel not scaled to full range");

  // zero command gives zero drive
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && out_strobe && $past(in_data == '0, PIPE_LAT)) |-> (out_data == '0))
    else $error("zero command gave nonzero drive");

endmodule

bind omni_wheel_mixer omw_checker u_omw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_strobe(out_strobe),
  .out_data  (out_data)
);

`default_nettype wire
